>>> design/chord_key_debounce_latch_assert.svh
// ----------------------------------------------------------------------------
// Chord key debounce latch assertion macros
// Concurrent assertion helpers, present in simulation and empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CHORD_KEY_DEBOUNCE_LATCH_ASSERT_SVH
`define CHORD_KEY_DEBOUNCE_LATCH_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define CKDL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ckdl assertion failed");

// Checked on every rising clock edge, also during reset.
`define CKDL_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("ckdl assertion failed");

`else

`define CKDL_ASSERT(lbl, prop)
`define CKDL_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> design/ckdl_pkg.sv
// ----------------------------------------------------------------------------
// Chord key debounce latch package
// Widths, vector masks, register indexes and reset values of the block.
// ----------------------------------------------------------------------------
package ckdl_pkg;

	// Width of the stability counter; it saturates at its all-ones value.
	localparam int COUNT_WIDTH = 16;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam int KEY_WIDTH = 5;
	localparam int VEC_WIDTH = 2 * KEY_WIDTH;

	// Modifier switches sit at vector bits 3, 4, 8 and 9; the rest are chord bits.
	localparam logic [VEC_WIDTH-1:0] MOD_KEEP_MASK = 10'b11_0001_1000;

	// Configuration register indexes (byte address is four times the index).
	typedef enum logic [2:0] {
		REG_SIDE_SELECT = 3'd0,
		REG_MOD_CODE_0  = 3'd1,
		REG_MOD_CODE_1  = 3'd2,
		REG_MOD_CODE_2  = 3'd3,
		REG_MOD_CODE_3  = 3'd4,
		REG_ALT_BITS    = 3'd5,
		REG_GUI_BITS    = 3'd6,
		REG_THRESHOLD   = 3'd7
	} reg_idx_t;

	localparam logic [7:0] MOD_CODE_0_RST = 8'd1;
	localparam logic [7:0] MOD_CODE_1_RST = 8'd2;
	localparam logic [7:0] MOD_CODE_2_RST = 8'd4;
	localparam logic [7:0] MOD_CODE_3_RST = 8'd8;
	localparam logic [7:0] ALT_BITS_RST   = 8'd4;
	localparam logic [7:0] GUI_BITS_RST   = 8'd8;
	localparam logic [7:0] THRESHOLD_RST  = 8'd15;

	// Chord code: vector bits 2..0 then bits 7..5.
	function automatic logic [5:0] chord_of(input logic [VEC_WIDTH-1:0] v);
		chord_of = {v[7:5], v[2:0]};
	endfunction

	// Modifier switch states 3..0 taken from vector bits 9, 8, 4, 3.
	function automatic logic [3:0] mod_sw_of(input logic [VEC_WIDTH-1:0] v);
		mod_sw_of = {v[9:8], v[4:3]};
	endfunction

endpackage

>>> design/chord_key_debounce_latch.sv
// ----------------------------------------------------------------------------
// Chord key debounce latch
// Joins two switch halves, debounces the key vector and decodes chord and
// modifier outputs once per scan beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on s_tvalid/s_tready/s_tdata carries one scan tick: the
//   local and remote 5-bit switch halves. Every input beat yields exactly one
//   output beat on m_tvalid/m_tready/m_tdata with the chord code, the mapped
//   modifier byte and the fn flag decoded from the updated latch.
//   A beat accepted at a clock edge has its result valid right after that edge.
//   Throughput is one beat per cycle unless m_tready stalls; the debounce state
//   and the decode are updated in a single pass into the output register. When
//   the receiver stalls, the output beat is held and s_tready stays high only if
//   the held beat is taken in the same cycle, so no beat is lost. Reset clears
//   the previous vector, latch, stability counter and release flag, empties the
//   output register and loads the register defaults. The user must write the
//   configuration over the APB port while no beat is in flight; not enforced.
// ----------------------------------------------------------------------------
module chord_key_debounce_latch
	import ckdl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [4:0] local_keys, [9:5] remote_keys, rest zero
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] chord_code, [13:6] modifier_byte,
	                               // [14] fn_layer, [15] zero
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

`include "chord_key_debounce_latch_assert.svh"

	// Configuration registers
	logic                   side_select_q;
	logic [7:0]             mod_code_q [4];
	logic [7:0]             alt_bits_q;
	logic [7:0]             gui_bits_q;
	logic [7:0]             threshold_q;

	// Debounce state
	logic [VEC_WIDTH-1:0]   prev_vec_q;
	logic [VEC_WIDTH-1:0]   latch_vec_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   pending_q;

	// Output register
	logic                   out_valid_q;
	logic [5:0]             out_chord_q;
	logic [7:0]             out_mod_q;
	logic                   out_fn_q;

	logic                   in_beat;
	logic                   cfg_wr;
	reg_idx_t               cfg_idx;
	logic [KEY_WIDTH-1:0]   local_keys;
	logic [KEY_WIDTH-1:0]   remote_keys;
	logic [VEC_WIDTH-1:0]   now_vec;
	logic                   pending_nxt;
	logic [COUNT_WIDTH-1:0] count_nxt;
	logic [VEC_WIDTH-1:0]   latch_nxt;
	logic [3:0]             mod_sw;
	logic [7:0]             mod_raw;
	logic                   fn_nxt;
	logic [7:0]             mod_nxt;

	// Handshakes
	assign s_tready = !out_valid_q || m_tready;
	assign in_beat  = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = reg_idx_t'(paddr[4:2]);

	// Configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_select_q <= 1'b0;
			mod_code_q[0] <= MOD_CODE_0_RST;
			mod_code_q[1] <= MOD_CODE_1_RST;
			mod_code_q[2] <= MOD_CODE_2_RST;
			mod_code_q[3] <= MOD_CODE_3_RST;
			alt_bits_q    <= ALT_BITS_RST;
			gui_bits_q    <= GUI_BITS_RST;
			threshold_q   <= THRESHOLD_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SIDE_SELECT: side_select_q <= pwdata[0];
				REG_MOD_CODE_0:  mod_code_q[0] <= pwdata[7:0];
				REG_MOD_CODE_1:  mod_code_q[1] <= pwdata[7:0];
				REG_MOD_CODE_2:  mod_code_q[2] <= pwdata[7:0];
				REG_MOD_CODE_3:  mod_code_q[3] <= pwdata[7:0];
				REG_ALT_BITS:    alt_bits_q    <= pwdata[7:0];
				REG_GUI_BITS:    gui_bits_q    <= pwdata[7:0];
				REG_THRESHOLD:   threshold_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Configuration read
	always_comb begin
		case (cfg_idx)
			REG_SIDE_SELECT: prdata = {31'd0, side_select_q};
			REG_MOD_CODE_0:  prdata = {24'd0, mod_code_q[0]};
			REG_MOD_CODE_1:  prdata = {24'd0, mod_code_q[1]};
			REG_MOD_CODE_2:  prdata = {24'd0, mod_code_q[2]};
			REG_MOD_CODE_3:  prdata = {24'd0, mod_code_q[3]};
			REG_ALT_BITS:    prdata = {24'd0, alt_bits_q};
			REG_GUI_BITS:    prdata = {24'd0, gui_bits_q};
			REG_THRESHOLD:   prdata = {24'd0, threshold_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Join the halves into the key vector.
	assign local_keys  = s_tdata[KEY_WIDTH-1:0];
	assign remote_keys = s_tdata[VEC_WIDTH-1:KEY_WIDTH];
	assign now_vec     = side_select_q ? {remote_keys, local_keys}
	                                   : {local_keys, remote_keys};

	// Debounce update: release tracking, saturating count and latch load.
	always_comb begin
		pending_nxt = pending_q;
		if ((chord_of(prev_vec_q) & ~chord_of(now_vec)) != 6'd0) begin
			pending_nxt = 1'b1;
		end
		if (chord_of(now_vec) == 6'd0) begin
			pending_nxt = 1'b0;
		end

		if (prev_vec_q == now_vec) begin
			count_nxt = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
		end else begin
			count_nxt = '0;
		end

		latch_nxt = latch_vec_q;
		if (count_nxt > {{(COUNT_WIDTH-8){1'b0}}, threshold_q}) begin
			latch_nxt = now_vec;
		end
		if (pending_nxt) begin
			latch_nxt = latch_nxt & MOD_KEEP_MASK;
		end
	end

	// Decode the updated latch into modifier byte and fn flag.
	always_comb begin
		mod_sw  = mod_sw_of(latch_nxt);
		mod_raw = 8'd0;
		for (int i = 0; i < 4; i++) begin
			if (mod_sw[i]) begin
				mod_raw = mod_raw | mod_code_q[i];
			end
		end
		fn_nxt  = ((mod_raw & alt_bits_q) != 8'd0) && ((mod_raw & gui_bits_q) != 8'd0);
		mod_nxt = fn_nxt ? (mod_raw & ~(alt_bits_q | gui_bits_q)) : mod_raw;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_vec_q  <= '0;
			latch_vec_q <= '0;
			count_q     <= '0;
			pending_q   <= 1'b0;
		end else if (in_beat) begin
			prev_vec_q  <= now_vec;
			latch_vec_q <= latch_nxt;
			count_q     <= count_nxt;
			pending_q   <= pending_nxt;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_chord_q <= chord_of(latch_nxt);
			out_mod_q   <= mod_nxt;
			out_fn_q    <= fn_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_fn_q, out_mod_q, out_chord_q};

	// While a release is pending the latch holds modifier bits only.
	`CKDL_ASSERT_ALWAYS(a_pending_chord_clear,
		pending_q |-> ((latch_vec_q & ~MOD_KEEP_MASK) == '0))
	// Every accepted beat leaves a result in the output register.
	`CKDL_ASSERT(a_beat_gives_result, in_beat |=> m_tvalid)
	// A changed vector restarts the stability count.
	`CKDL_ASSERT(a_change_clears_count,
		(in_beat && (now_vec != prev_vec_q)) |=> (count_q == '0))
	// The counter holds at its maximum on a repeated vector.
	`CKDL_ASSERT(a_count_saturates,
		(in_beat && (now_vec == prev_vec_q) && (count_q == COUNT_MAX)) |=>
		(count_q == COUNT_MAX))

endmodule
